[hw/rtl/msr_pkg.sv]
package msr_pkg;

  localparam int KEY_W   = 2;
  localparam int SPEED_W = 10;
  localparam int TICKS_W = 8;
  localparam int MODE_W  = 2;
  localparam int CFG_AW  = 1;

  localparam logic [SPEED_W-1:0] SpeedMax = 10'd996;

  typedef enum logic [MODE_W-1:0] {
    MODE_STOP  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_FAULT = 2'd2
  } mode_t;

  typedef enum logic [KEY_W-1:0] {
    KEY_RUN  = 2'd0,
    KEY_STOP = 2'd1,
    KEY_DIR  = 2'd2,
    KEY_NONE = 2'd3
  } key_t;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_ACCEL_TICKS = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_DECEL_TICKS = 1'b1;

  typedef struct packed {
    mode_t              mode;
    logic [SPEED_W-1:0] speed;
    logic [TICKS_W-1:0] accel_count;
    logic [TICKS_W-1:0] decel_count;
    logic               stop_req;
    logic               rev_req;
    logic               dir;
    logic [KEY_W-1:0]   last_key;
  } ctl_state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key_sel;
    logic               fault_n;
    logic [SPEED_W-1:0] target_speed;
  } tick_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_now;
    logic [MODE_W-1:0]  mode_now;
    logic               direction;
    logic               pwm_active;
  } result_t;

endpackage

[hw/rtl/msr_req_if.sv]
interface msr_req_if;
  logic                        valid;
  logic                        ready;
  logic [msr_pkg::KEY_W-1:0]   key_sel;
  logic                        fault_n;
  logic [msr_pkg::SPEED_W-1:0] target_speed;

  modport source (output valid, key_sel, fault_n, target_speed, input ready);
  modport sink (input valid, key_sel, fault_n, target_speed, output ready);
endinterface

[hw/rtl/msr_res_if.sv]
interface msr_res_if;
  logic                        valid;
  logic                        ready;
  logic [msr_pkg::SPEED_W-1:0] speed_now;
  logic [msr_pkg::MODE_W-1:0]  mode_now;
  logic                        direction;
  logic                        pwm_active;

  modport source (output valid, speed_now, mode_now, direction, pwm_active, input ready);
  modport sink (input valid, speed_now, mode_now, direction, pwm_active, output ready);
endinterface

[hw/rtl/msr_cfg_if.sv]
interface msr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [msr_pkg::CFG_AW-1:0]  addr;
  logic [msr_pkg::TICKS_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

[hw/rtl/msr_step.sv]
module msr_step (
  input  msr_pkg::ctl_state_t          cur,
  input  msr_pkg::tick_t               tick,
  input  logic [msr_pkg::TICKS_W-1:0]  accel_ticks,
  input  logic [msr_pkg::TICKS_W-1:0]  decel_ticks,
  output msr_pkg::ctl_state_t          nxt,
  output msr_pkg::result_t             result
);
  import msr_pkg::*;

  logic               key_edge;
  logic               fault;
  logic [SPEED_W-1:0] tgt_sat;
  logic [SPEED_W-1:0] goal;
  logic [TICKS_W-1:0] acc_inc;
  logic [TICKS_W-1:0] dec_inc;
  logic [SPEED_W-1:0] speed_dec;

  assign key_edge = (tick.key_sel != cur.last_key);
  assign fault    = ~tick.fault_n;
  assign tgt_sat  = (tick.target_speed > SpeedMax) ? SpeedMax : tick.target_speed;

  always_comb begin
    nxt = cur;

    // key and fault handling
    unique case (cur.mode)
      MODE_RUN: begin
        if (fault) begin
          nxt.stop_req = 1'b0;
          nxt.rev_req  = 1'b0;
          nxt.mode     = MODE_FAULT;
        end else if (key_edge && tick.key_sel == KEY_STOP) begin
          nxt.stop_req = 1'b1;
        end else if (key_edge && tick.key_sel == KEY_DIR) begin
          nxt.stop_req = 1'b1;
          nxt.rev_req  = 1'b1;
        end
      end
      MODE_FAULT: begin
        if (!fault && key_edge && tick.key_sel == KEY_STOP) begin
          nxt.mode = MODE_STOP;
        end
      end
      default: begin
        if (fault) begin
          nxt.mode = MODE_FAULT;
        end else if (key_edge && tick.key_sel == KEY_RUN) begin
          nxt.mode = MODE_RUN;
        end else if (key_edge && tick.key_sel == KEY_DIR) begin
          nxt.dir = ~cur.dir;
        end
      end
    endcase
    nxt.last_key = tick.key_sel;

    // ramp one step toward the goal
    goal      = nxt.stop_req ? '0 : tgt_sat;
    acc_inc   = nxt.accel_count + 8'd1;
    dec_inc   = nxt.decel_count + 8'd1;
    speed_dec = nxt.speed - 10'd1;
    if (nxt.mode != MODE_RUN || nxt.speed == goal) begin
      nxt.accel_count = '0;
      nxt.decel_count = '0;
    end else if (nxt.speed < goal) begin
      nxt.decel_count = '0;
      if (acc_inc >= accel_ticks) begin
        nxt.accel_count = '0;
        nxt.speed       = nxt.speed + 10'd1;
      end else begin
        nxt.accel_count = acc_inc;
      end
    end else begin
      nxt.accel_count = '0;
      if (dec_inc >= decel_ticks) begin
        nxt.decel_count = '0;
        nxt.speed       = speed_dec;
        if (speed_dec == '0 && nxt.stop_req) begin
          nxt.stop_req = 1'b0;
          if (nxt.rev_req) begin
            nxt.rev_req = 1'b0;
            nxt.dir     = ~nxt.dir;
          end else begin
            nxt.mode = MODE_STOP;
          end
        end
      end else begin
        nxt.decel_count = dec_inc;
      end
    end

    result.speed_now  = nxt.speed;
    result.mode_now   = nxt.mode;
    result.direction  = nxt.dir;
    result.pwm_active = (nxt.mode == MODE_RUN) && (nxt.speed != '0);
  end

endmodule

[hw/rtl/motor_speed_ramp_mode_control.sv]
// Channel  Role    Payload                                    Handshake
// req      sink    key_sel[1:0], fault_n, target_speed[9:0]   valid/ready
// res      source  speed_now[9:0], mode_now[1:0], direction,  valid/ready
//                  pwm_active
// cfg      sink    addr[0] (0 accel_ticks, 1 decel_ticks),    valid/ready (ready always 1)
//                  data[7:0]
//
// One request per clock sustained while res.ready holds.
// The tick update is one combinational pass from the input register into the state and
// result registers; the state loop closes through that pass alone.
// Reset (rst, synchronous) returns to stop mode, speed zero, no key, ticks registers to 1.
// A stalled result is held in the output register and a second one in a skid register;
// req.ready drops only while the skid register is full.
module motor_speed_ramp_mode_control (
  input  logic      clk,
  input  logic      rst,
  msr_req_if.sink   req,
  msr_res_if.source res,
  msr_cfg_if.sink   cfg
);
  import msr_pkg::*;

  // configuration registers
  logic [TICKS_W-1:0] accel_ticks;
  logic [TICKS_W-1:0] decel_ticks;

  // controller state
  ctl_state_t state;
  ctl_state_t state_next;

  // input register
  logic  in_valid;
  tick_t in_tick;

  // output register and skid register
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  result_t step_result;

  logic req_fire;
  logic step_fire;

  // accept a new request unless the input register and the skid register both hold one
  assign req.ready = ~in_valid | ~skid_valid;
  assign req_fire  = req.valid & req.ready;
  assign step_fire = in_valid & ~skid_valid;

  // config writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_ticks <= 8'd1;
      decel_ticks <= 8'd1;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        CFG_ACCEL_TICKS: accel_ticks <= cfg.data;
        CFG_DECEL_TICKS: decel_ticks <= cfg.data;
      endcase
    end
  end

  // hold the request until the step consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= req_fire | (in_valid & ~step_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      in_tick.key_sel      <= req.key_sel;
      in_tick.fault_n      <= req.fault_n;
      in_tick.target_speed <= req.target_speed;
    end
  end

  msr_step u_step (
    .cur         (state),
    .tick        (in_tick),
    .accel_ticks (accel_ticks),
    .decel_ticks (decel_ticks),
    .nxt         (state_next),
    .result      (step_result)
  );

  // advance the controller state once per consumed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode        <= MODE_STOP;
      state.speed       <= '0;
      state.accel_count <= '0;
      state.decel_count <= '0;
      state.stop_req    <= 1'b0;
      state.rev_req     <= 1'b0;
      state.dir         <= 1'b0;
      state.last_key    <= KEY_NONE;
    end else if (step_fire) begin
      state <= state_next;
    end
  end

  // output register with skid: drain skid first, park a result there on a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || res.ready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= step_fire;
        end
      end else if (step_fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || res.ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (step_fire) begin
        out_data <= step_result;
      end
    end else if (step_fire) begin
      skid_data <= step_result;
    end
  end

  assign res.valid      = out_valid;
  assign res.speed_now  = out_data.speed_now;
  assign res.mode_now   = out_data.mode_now;
  assign res.direction  = out_data.direction;
  assign res.pwm_active = out_data.pwm_active;

  // skid register only fills behind a stalled output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register valid while output register empty");

  // ramp never leaves the speed range
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    state.speed <= SpeedMax)
    else $error("speed above range");

  // ramp counters stay clear outside run mode
  a_counters_idle: assert property (@(posedge clk) disable iff (rst)
    state.mode != MODE_RUN |-> (state.accel_count == '0 && state.decel_count == '0))
    else $error("ramp counter running outside run mode");

  // fault mode exits only to stop
  a_fault_exit: assert property (@(posedge clk) disable iff (rst)
    (state.mode == MODE_FAULT) ##1 (state.mode != MODE_FAULT) |-> state.mode == MODE_STOP)
    else $error("fault mode left to a mode other than stop");

endmodule
